>>> src/bld_pkg.sv
`default_nettype none

package bld_pkg;

   localparam int DATA_WIDTH       = 32;
   localparam int OPCODE_WIDTH     = 3;
   localparam int STATUS_WIDTH     = 2;
   localparam int CAPACITY_DEFAULT = 16;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_PUSH_HEAD = 3'd0,
      OP_PUSH_TAIL = 3'd1,
      OP_POP_HEAD  = 3'd2,
      OP_PEEK_HEAD = 3'd3,
      OP_PEEK_TAIL = 3'd4,
      OP_SEARCH    = 3'd5,
      OP_MODIFY    = 3'd6,
      OP_CLEAR     = 3'd7
   } op_type;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL      = 2'd2;

endpackage

`default_nettype wire

>>> src/bounded_list_deque_with_search.sv
// Bounded double-ended list of signed 32-bit values with search and modify.
// Items enter on the req_ channel (opcode, value, replacement) and each one
// yields exactly one item on the rsp_ channel, both with valid/ready handshakes.
// One item is processed at a time; req_ready is high whenever the controller
// is idle, even while a finished result still waits in the output register.
// Push, clear, any operation that ends in a full or underflow status, and a
// search or modify of an empty list go from the execute state straight to the
// done state; pop and peek pass through the read state, and search and modify
// through the scan state, which reads entries up to and including the first
// match (at most the entry count, so at most CAPACITY). The done state moves
// the result into the output register once it is free. The scan reads one entry
// per cycle through the single read port of the entry memory, and that port
// sets the rate of search and modify.
// Reset empties the list and drops any pending result; the entry memory is
// not cleared, since only entries inside the list are ever read.
// When the receiver stalls, the result is held in the output register; the
// next item may be accepted and worked on, but its result waits until the
// output register has been emptied.
`default_nettype none

module bounded_list_deque_with_search #(
   parameter int CAPACITY = bld_pkg::CAPACITY_DEFAULT,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic        [bld_pkg::OPCODE_WIDTH-1:0] req_opcode,
   input  wire logic signed [bld_pkg::DATA_WIDTH-1:0]   req_value,
   input  wire logic signed [bld_pkg::DATA_WIDTH-1:0]   req_replacement,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic signed      [bld_pkg::DATA_WIDTH-1:0]   rsp_read_value,
   output logic                                         rsp_found,
   output logic             [bld_pkg::STATUS_WIDTH-1:0] rsp_status,
   output logic             [CW-1:0]                    rsp_count,
   output logic                                         rsp_empty_res
);

   import bld_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam logic [CW:0]   CAP_EXT  = (CW + 1)'(CAPACITY);
   localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
   localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_READ = 5'b00100,
      S_SCAN = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type                      state_ff, state_in;
   op_type                         op_ff, op_in;
   logic signed [DATA_WIDTH-1:0]   value_ff, value_in;
   logic signed [DATA_WIDTH-1:0]   repl_ff, repl_in;
   logic        [IW-1:0]           head_ff, head_in;
   logic        [CW-1:0]           count_ff, count_in;
   logic        [IW-1:0]           scan_addr_ff, scan_addr_in;
   logic        [CW-1:0]           scan_cnt_ff, scan_cnt_in;
   logic signed [DATA_WIDTH-1:0]   res_value_ff, res_value_in;
   logic                           res_found_ff, res_found_in;
   logic        [STATUS_WIDTH-1:0] res_status_ff, res_status_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_WIDTH-1:0]   rsp_value_ff, rsp_value_in;
   logic                           rsp_found_ff, rsp_found_in;
   logic        [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;
   logic        [CW-1:0]           rsp_count_ff, rsp_count_in;
   logic                           rsp_empty_ff, rsp_empty_in;

   logic                  mem_wr_en;
   logic [IW-1:0]         mem_wr_addr;
   logic [DATA_WIDTH-1:0] mem_wr_data;
   logic                  mem_rd_en;
   logic [IW-1:0]         mem_rd_addr;
   logic [DATA_WIDTH-1:0] mem_rd_data;

   logic          list_full;
   logic          list_empty;
   logic [IW-1:0] head_dec;
   logic [IW-1:0] head_inc;
   logic [IW-1:0] tail_pos;
   logic [IW-1:0] last_pos;
   logic [IW-1:0] scan_next;

   // Ring position of head plus an offset, for sums below twice the capacity.
   function automatic logic [IW-1:0] ring_wrap(input logic [CW:0] sum);
      logic [CW:0] red;
      red = (sum >= CAP_EXT) ? (sum - CAP_EXT) : sum;
      return red[IW-1:0];
   endfunction

   assign list_full  = (count_ff == CAP_CNT);
   assign list_empty = (count_ff == '0);
   assign head_dec   = (head_ff == '0) ? LAST_IDX : head_ff - IW'(1);
   assign head_inc   = (head_ff == LAST_IDX) ? '0 : head_ff + IW'(1);
   assign scan_next  = (scan_addr_ff == LAST_IDX) ? '0 : scan_addr_ff + IW'(1);
   assign tail_pos   = ring_wrap((CW + 1)'(head_ff) + (CW + 1)'(count_ff));
   assign last_pos   = ring_wrap((CW + 1)'(head_ff) + (CW + 1)'(count_ff) - (CW + 1)'(1));

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      repl_in       = repl_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      scan_addr_in  = scan_addr_ff;
      scan_cnt_in   = scan_cnt_ff;
      res_value_in  = res_value_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = head_ff;
      mem_wr_data   = value_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = head_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = op_type'(req_opcode);
               value_in = req_value;
               repl_in  = req_replacement;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_value_in  = '0;
            res_found_in  = 1'b0;
            res_status_in = STATUS_OK;
            state_in      = S_DONE;
            unique case (op_ff)
               OP_PUSH_HEAD: begin
                  if (list_full) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = head_dec;
                     head_in     = head_dec;
                     count_in    = count_ff + CW'(1);
                  end
               end
               OP_PUSH_TAIL: begin
                  if (list_full) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = tail_pos;
                     count_in    = count_ff + CW'(1);
                  end
               end
               OP_POP_HEAD, OP_PEEK_HEAD: begin
                  if (list_empty) begin
                     res_status_in = STATUS_UNDERFLOW;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = head_ff;
                     state_in    = S_READ;
                  end
               end
               OP_PEEK_TAIL: begin
                  if (list_empty) begin
                     res_status_in = STATUS_UNDERFLOW;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = last_pos;
                     state_in    = S_READ;
                  end
               end
               OP_SEARCH, OP_MODIFY: begin
                  if (!list_empty) begin
                     mem_rd_en    = 1'b1;
                     mem_rd_addr  = head_ff;
                     scan_addr_in = head_ff;
                     scan_cnt_in  = CW'(1);
                     state_in     = S_SCAN;
                  end
               end
               OP_CLEAR: begin
                  count_in = '0;
                  head_in  = '0;
               end
            endcase
         end
         S_READ: begin
            res_value_in = mem_rd_data;
            if (op_ff == OP_POP_HEAD) begin
               head_in  = head_inc;
               count_in = count_ff - CW'(1);
            end
            state_in = S_DONE;
         end
         S_SCAN: begin
            // The read data belongs to the entry at scan_addr_ff.
            if (mem_rd_data == value_ff) begin
               res_found_in = 1'b1;
               if (op_ff == OP_MODIFY) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = scan_addr_ff;
                  mem_wr_data = repl_ff;
               end
               state_in = S_DONE;
            end else if (scan_cnt_ff == count_ff) begin
               state_in = S_DONE;
            end else begin
               mem_rd_en    = 1'b1;
               mem_rd_addr  = scan_next;
               scan_addr_in = scan_next;
               scan_cnt_in  = scan_cnt_ff + CW'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_found_in  = res_found_ff;
               rsp_status_in = res_status_ff;
               rsp_count_in  = count_ff;
               rsp_empty_in  = list_empty;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      value_ff      <= value_in;
      repl_ff       <= repl_in;
      scan_addr_ff  <= scan_addr_in;
      scan_cnt_ff   <= scan_cnt_in;
      res_value_ff  <= res_value_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   bld_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_empty_res  = rsp_empty_ff;

endmodule

`default_nettype wire

>>> src/bld_ram.sv
`default_nettype none

module bld_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/bld_checker.sv
`default_nettype none

module bld_checker #(
   parameter int CAPACITY = bld_pkg::CAPACITY_DEFAULT,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input wire logic                                    clock,
   input wire logic                                    reset,
   input wire logic                                    rsp_valid,
   input wire logic signed [bld_pkg::DATA_WIDTH-1:0]   rsp_read_value,
   input wire logic                                    rsp_found,
   input wire logic        [bld_pkg::STATUS_WIDTH-1:0] rsp_status,
   input wire logic        [CW-1:0]                    rsp_count,
   input wire logic                                    rsp_empty_res
);

   import bld_pkg::*;

   // A pending result is dropped by reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result still valid after reset");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_empty_res == (rsp_count == '0)) && (rsp_count <= CW'(CAPACITY)))
      else $error("empty flag or count inconsistent");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL) |-> (rsp_count == CW'(CAPACITY)) && !rsp_found)
      else $error("full status while list not full");

   a_underflow_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_UNDERFLOW) |->
         (rsp_count == '0) && (rsp_read_value == '0) && !rsp_found)
      else $error("underflow status with entries or data");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_UNDERFLOW ||
                     rsp_status == STATUS_FULL))
      else $error("undefined status code");

endmodule

bind bounded_list_deque_with_search bld_checker #(
   .CAPACITY (CAPACITY)
) u_bld_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_read_value (rsp_read_value),
   .rsp_found      (rsp_found),
   .rsp_status     (rsp_status),
   .rsp_count      (rsp_count),
   .rsp_empty_res  (rsp_empty_res)
);

`default_nettype wire

>>> test/bounded_list_deque_with_search_test.sv
module bounded_list_deque_with_search_test;
   import bld_pkg::*;

   localparam int CAP         = CAPACITY_DEFAULT;
   localparam int COUNT_W     = $clog2(CAP + 1);
   localparam int POOL_SIZE   = 8;
   localparam int HOLD_CYCLES = 80;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 40;

   typedef enum {PH_STEADY, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH_IDLE, PH_PRESSURE} phase_type;
   typedef enum {BIAS_FILL, BIAS_DRAIN, BIAS_MIXED} bias_type;

   typedef struct {
      op_type                         op;
      logic signed [DATA_WIDTH-1:0]   value;
      logic signed [DATA_WIDTH-1:0]   replacement;
   } list_op_type;

   typedef struct {
      logic signed [DATA_WIDTH-1:0]   read_value;
      logic                           found;
      logic        [STATUS_WIDTH-1:0] status;
      logic        [COUNT_W-1:0]      count;
      logic                           empty_res;
   } list_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic        [OPCODE_WIDTH-1:0]      req_opcode = '0;
   logic signed [DATA_WIDTH-1:0]        req_value = '0;
   logic signed [DATA_WIDTH-1:0]        req_replacement = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic signed [DATA_WIDTH-1:0]        rsp_read_value;
   logic                                rsp_found;
   logic        [STATUS_WIDTH-1:0]      rsp_status;
   logic        [COUNT_W-1:0]           rsp_count;
   logic                                rsp_empty_res;

   bounded_list_deque_with_search #(.CAPACITY(CAP)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_value       (req_value),
      .req_replacement (req_replacement),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_found       (rsp_found),
      .rsp_status      (rsp_status),
      .rsp_count       (rsp_count),
      .rsp_empty_res   (rsp_empty_res)
   );

   phase_type                     phase = PH_STEADY;
   list_op_type                   op_queue[$];
   list_result_type               predicted_results[$];
   logic signed [DATA_WIDTH-1:0]  value_pool[POOL_SIZE];

   // Shadow copy of the list.
   logic signed [DATA_WIDTH-1:0]  ring[CAP];
   int                            ring_head = 0;
   int                            ring_held = 0;

   int failures = 0;
   int items_taken = 0;
   int results_checked = 0;
   int full_pushes = 0;
   int underflows = 0;
   int match_hits = 0;
   int deepest = 0;
   int quiet_cycles = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int send_idle_pct(phase_type p);
      case (p)
         PH_SEND_IDLE: return 74;
         PH_BOTH_IDLE: return 29;
         default:      return 0;
      endcase
   endfunction

   function automatic int recv_stall_pct(phase_type p);
      case (p)
         PH_RECV_STALL: return 74;
         PH_BOTH_IDLE:  return 29;
         default:       return 0;
      endcase
   endfunction

   // Applies one operation to the shadow list and returns the result it yields.
   function automatic list_result_type apply_list_op(op_type op,
                                                     logic signed [DATA_WIDTH-1:0] val,
                                                     logic signed [DATA_WIDTH-1:0] rep);
      list_result_type r;
      int              pos;
      r.read_value = '0;
      r.found      = 1'b0;
      r.status     = STATUS_OK;
      case (op)
         OP_PUSH_HEAD: begin
            if (ring_held >= CAP) begin
               r.status = STATUS_FULL;
            end else begin
               ring_head = (ring_head + CAP - 1) % CAP;
               ring[ring_head] = val;
               ring_held++;
            end
         end
         OP_PUSH_TAIL: begin
            if (ring_held >= CAP) begin
               r.status = STATUS_FULL;
            end else begin
               ring[(ring_head + ring_held) % CAP] = val;
               ring_held++;
            end
         end
         OP_POP_HEAD: begin
            if (ring_held == 0) begin
               r.status = STATUS_UNDERFLOW;
            end else begin
               r.read_value = ring[ring_head];
               ring_head = (ring_head + 1) % CAP;
               ring_held--;
            end
         end
         OP_PEEK_HEAD: begin
            if (ring_held == 0) r.status = STATUS_UNDERFLOW;
            else r.read_value = ring[ring_head];
         end
         OP_PEEK_TAIL: begin
            if (ring_held == 0) r.status = STATUS_UNDERFLOW;
            else r.read_value = ring[(ring_head + ring_held - 1) % CAP];
         end
         OP_SEARCH, OP_MODIFY: begin
            for (int i = 0; i < ring_held; i++) begin
               pos = (ring_head + i) % CAP;
               if (!r.found && ring[pos] == val) begin
                  r.found = 1'b1;
                  if (op == OP_MODIFY) ring[pos] = rep;
               end
            end
         end
         OP_CLEAR: begin
            ring_held = 0;
            ring_head = 0;
         end
      endcase
      r.count     = COUNT_W'(ring_held);
      r.empty_res = (ring_held == 0);
      return r;
   endfunction

   // Sender: a new item is offered only once the previous one has been taken.
   always @(posedge clock) begin : driver
      list_op_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct(phase)) begin
            next_item = op_queue.pop_front();
            req_valid       <= 1'b1;
            req_opcode      <= next_item.op;
            req_value       <= next_item.value;
            req_replacement <= next_item.replacement;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off when the pressure phase begins.
   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (phase == PH_PRESSURE && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct(phase));
      end
   end

   always @(posedge clock) begin : monitor
      list_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               $error("result arrived with no item outstanding");
               failures++;
            end else begin
               want = predicted_results.pop_front();
               results_checked++;
               if (rsp_read_value !== want.read_value) begin
                  $error("read_value: expected %0d, got %0d", want.read_value, rsp_read_value);
                  failures++;
               end
               if (rsp_found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_found);
                  failures++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  failures++;
               end
               if (rsp_count !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, rsp_count);
                  failures++;
               end
               if (rsp_empty_res !== want.empty_res) begin
                  $error("empty_res: expected %0d, got %0d", want.empty_res, rsp_empty_res);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready) begin
            want = apply_list_op(op_type'(req_opcode), req_value, req_replacement);
            predicted_results.push_back(want);
            items_taken++;
            if (want.status == STATUS_FULL) full_pushes++;
            if (want.status == STATUS_UNDERFLOW) underflows++;
            if (want.found) match_hits++;
            if (ring_held > deepest) deepest = ring_held;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic add_item(op_type op, logic signed [DATA_WIDTH-1:0] val,
                           logic signed [DATA_WIDTH-1:0] rep);
      list_op_type item;
      item.op          = op;
      item.value       = val;
      item.replacement = rep;
      op_queue.push_back(item);
   endtask

   // Values mostly come from a small pool, so that searches and modifies often match
   // and duplicates make the first match matter.
   function automatic logic signed [DATA_WIDTH-1:0] pick_value();
      if ($urandom_range(3) == 0) return $urandom;
      return value_pool[$urandom_range(POOL_SIZE - 1)];
   endfunction

   function automatic op_type pick_op(bias_type bias);
      int roll;
      int push_pct;
      int pop_pct;
      roll = $urandom_range(99);
      case (bias)
         BIAS_FILL:  begin push_pct = 70; pop_pct = 8;  end
         BIAS_DRAIN: begin push_pct = 15; pop_pct = 45; end
         default:    begin push_pct = 35; pop_pct = 20; end
      endcase
      if (roll < 2) return OP_CLEAR;
      if (roll < 2 + push_pct) return $urandom_range(1) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
      if (roll < 2 + push_pct + pop_pct) return OP_POP_HEAD;
      return op_type'($urandom_range(int'(OP_PEEK_HEAD), int'(OP_MODIFY)));
   endfunction

   task automatic add_random_items(int n);
      bias_type bias;
      bias = BIAS_MIXED;
      for (int i = 0; i < n; i++) begin
         if (i % 20 == 0) bias = bias_type'($urandom_range(2));
         add_item(pick_op(bias), pick_value(), pick_value());
      end
   endtask

   task automatic wait_until_idle();
      while (op_queue.size() != 0 || req_valid || predicted_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(phase_type p, int n);
      @(posedge clock);
      phase <= p;
      add_random_items(n);
      wait_until_idle();
   endtask

   initial begin
      value_pool[0] = 32'sh7FFF_FFFF;
      value_pool[1] = 32'sh8000_0000;
      value_pool[2] = '0;
      value_pool[3] = -32'sd1;
      for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part: pop, peek, search and modify on an empty list, a fill to capacity
      // with the extreme values, pushes on a full list, then the remaining operations.
      add_item(OP_POP_HEAD,  '0, '0);
      add_item(OP_PEEK_HEAD, '0, '0);
      add_item(OP_PEEK_TAIL, '0, '0);
      add_item(OP_SEARCH,    '0, '0);
      add_item(OP_MODIFY,    '0, -32'sd1);
      add_item(OP_PUSH_TAIL, 32'sh7FFF_FFFF, '0);
      add_item(OP_PUSH_HEAD, 32'sh8000_0000, '0);
      add_item(OP_PUSH_TAIL, -32'sd1, '0);
      add_item(OP_PUSH_HEAD, '0, '0);
      for (int i = 4; i < CAP; i++)
         add_item((i % 2) ? OP_PUSH_HEAD : OP_PUSH_TAIL, $urandom, '0);
      add_item(OP_PUSH_TAIL, 32'sh1234_5678, '0);
      add_item(OP_PUSH_HEAD, 32'sh1234_5678, '0);
      add_item(OP_PEEK_HEAD, '0, '0);
      add_item(OP_PEEK_TAIL, '0, '0);
      add_item(OP_SEARCH,    32'sh7FFF_FFFF, '0);
      add_item(OP_MODIFY,    -32'sd1, 32'sh5555_AAAA);
      add_item(OP_MODIFY,    32'sh0BAD_F00D, 32'sh7FFF_FFFF);
      add_item(OP_POP_HEAD,  '0, '0);
      add_item(OP_CLEAR,     '0, '0);
      wait_until_idle();

      run_phase(PH_STEADY, 165);
      run_phase(PH_SEND_IDLE, 165);
      run_phase(PH_RECV_STALL, 165);
      run_phase(PH_BOTH_IDLE, 165);
      run_phase(PH_PRESSURE, 40);

      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Checked %0d results for %0d items; deepest list %0d of %0d entries.",
               results_checked, items_taken, deepest, CAP);
      $display("Full pushes %0d, underflows %0d, search or modify matches %0d.",
               full_pushes, underflows, match_hits);
      if (failures == 0 && predicted_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> sim.f
src/bld_pkg.sv
src/bld_ram.sv
src/bounded_list_deque_with_search.sv
src/bld_checker.sv
test/bounded_list_deque_with_search_test.sv
